>>> hw/rtl/fmts_pkg.sv
// Shared types, codes and constants of the Fourier mode turbulence synthesizer.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps
package fmts_pkg;

  localparam int N_MODES_DEF   = 32;
  localparam int N_SEEDS_DEF   = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int ROOT_STEPS = 32;
  localparam int DIV_LONG_STEPS  = 64;
  localparam int DIV_SHORT_STEPS = 32;

  localparam logic [1:0] CMD_LOAD_MODE = 2'd0;
  localparam logic [1:0] CMD_LOAD_SEED = 2'd1;
  localparam logic [1:0] CMD_COMPUTE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINLEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MINVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 3'd4;

  // odd quarter-wave sine polynomial, Q30
  localparam logic [31:0] SIN_A1 = 32'd1686629713;
  localparam logic [31:0] SIN_A3 = 32'd693598668;
  localparam logic [31:0] SIN_A5 = 32'd85569306;
  localparam logic [31:0] SIN_A7 = 32'd5026995;
  localparam logic [31:0] SIN_A9 = 32'd172272;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         slot;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic signed [31:0] vec_b_z;
    logic signed [31:0] vec_c_x;
    logic signed [31:0] vec_c_y;
    logic signed [31:0] vec_c_z;
  } fmts_in_t;

  typedef struct packed {
    logic [7:0]         node_tag;
    logic signed [31:0] flu_axial;
    logic signed [31:0] flu_lateral;
    logic signed [31:0] flu_vertical;
  } fmts_out_t;

endpackage

>>> hw/rtl/fmts_sqrt.sv
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on fmts_pkg.
`timescale 1ns / 1ps
module fmts_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import fmts_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] v_q, r_q, b_q;
  logic [63:0] trial;
  logic        ge;

  assign trial = r_q + b_q;
  assign ge    = (v_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(ROOT_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= rad_i;
      r_q <= '0;
      b_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (ge) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

>>> hw/rtl/fmts_div.sv
// Iterative restoring divider: 64 or 32 quotient steps, one bit per cycle.
// Divisor below 2^31, held by the caller while busy. Depends on fmts_pkg.
`timescale 1ns / 1ps
module fmts_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        long_i,
  input  logic [63:0] dvd_i,
  input  logic [30:0] rem_i,
  input  logic [30:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [30:0] rem_o
);
  import fmts_pkg::*;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [31:0] rem_q, quo_q;
  logic [63:0] dvd_q;
  logic [31:0] shifted;
  logic        ge;

  assign shifted = {rem_q[30:0], dvd_q[63]};
  assign ge      = (shifted >= {1'b0, den_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= long_i ? 7'(DIV_LONG_STEPS) : 7'(DIV_SHORT_STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, rem_i};
      dvd_q <= dvd_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (shifted - {1'b0, den_i}) : shifted;
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[30:0];

endmodule

>>> hw/rtl/fourier_mode_turbulence_synth_unit.sv
// Fourier mode turbulence synthesizer: one node per compute request.
// Compute makes two seed passes over the active modes, with a shared divider and root; a
// pass stops on a bad seed index, no modes or length <= 0; cut-off modes add nothing.
// One request at a time; ready only while idle. Reset clears control and sets registers
// to their defaults; mode and seed tables are undefined until loaded.
// Depends on fmts_pkg, fmts_sqrt, fmts_div.
`timescale 1ns / 1ps
module fourier_mode_turbulence_synth_unit #(
  parameter int N_MODES   = fmts_pkg::N_MODES_DEF,
  parameter int N_SEEDS   = fmts_pkg::N_SEEDS_DEF,
  parameter int FRAC_BITS = fmts_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fmts_pkg::fmts_in_t                  in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fmts_pkg::fmts_out_t                 out_rsp_o,
  input  logic                                cfg_we_i,
  input  logic [fmts_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fmts_pkg::WORD_W-1:0]         cfg_data_i
);
  import fmts_pkg::*;

  localparam int MA_W = (N_MODES > 1) ? $clog2(N_MODES) : 1;
  localparam int SA_W = (N_SEEDS > 1) ? $clog2(N_SEEDS) : 1;
  localparam int MC_W = $clog2(N_MODES + 1);
  localparam logic [63:0] QONE = 64'd1 << FRAC_BITS;

  localparam logic [5:0] ST_IDLE = 6'd0,  ST_SQ1  = 6'd1,  ST_SQ2  = 6'd2,  ST_PASS = 6'd3,
                         ST_SRD  = 6'd4,  ST_SEED = 6'd5,  ST_GAIN = 6'd6,  ST_MRD  = 6'd7,
                         ST_K0   = 6'd8,  ST_K1   = 6'd9,  ST_K2   = 6'd10, ST_K3   = 6'd11,
                         ST_K4   = 6'd12, ST_K5   = 6'd13, ST_K6   = 6'd14, ST_CUTL = 6'd15,
                         ST_SQK  = 6'd16, ST_CUT  = 6'd17, ST_DRIFT = 6'd18, ST_NUM = 6'd19,
                         ST_DIV1 = 6'd20, ST_DIV2 = 6'd21, ST_TSET = 6'd22, ST_T0   = 6'd23,
                         ST_T1   = 6'd24, ST_T2   = 6'd25, ST_T3   = 6'd26, ST_T4   = 6'd27,
                         ST_T5   = 6'd28, ST_T6   = 6'd29, ST_C0   = 6'd30, ST_C1   = 6'd31,
                         ST_C2   = 6'd32, ST_C3   = 6'd33, ST_NEXT = 6'd34, ST_PEND = 6'd35,
                         ST_FIN  = 6'd36;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647)        sat32 = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648)  sat32 = 32'sh8000_0000;
    else                            sat32 = v[31:0];
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_4000_0000_0000_0000)       sat_add = 64'sh4000_0000_0000_0000;
    else if (s < -65'sh0_4000_0000_0000_0000) sat_add = -64'sh4000_0000_0000_0000;
    else                                      sat_add = s[63:0];
  endfunction

  function automatic logic signed [32:0] sx33(input logic [31:0] v);
    sx33 = {v[31], v};
  endfunction

  function automatic logic signed [32:0] zx33(input logic [31:0] v);
    zx33 = {1'b0, v};
  endfunction

  // configuration
  logic [30:0]        cutoff_q, mesh_q, minlen_q;
  logic signed [31:0] minvel_q;
  logic [5:0]         active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 31'd65536;
      mesh_q   <= 31'd65536;
      minlen_q <= 31'd655360;
      minvel_q <= '0;
      active_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CUTOFF: cutoff_q <= cfg_data_i[30:0];
        CFG_MESH:   mesh_q   <= cfg_data_i[30:0];
        CFG_MINLEN: minlen_q <= cfg_data_i[30:0];
        CFG_MINVEL: minvel_q <= cfg_data_i;
        CFG_ACTIVE: active_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // tables
  logic [8:0][31:0] mode_mem [N_MODES];
  logic [2:0][31:0] seed_mem [N_SEEDS];
  logic [8:0][31:0] mode_rd_q;
  logic [2:0][31:0] seed_rd_q;

  logic [5:0]         state_q;
  logic               accept;
  logic [7:0]         tag_q;
  logic signed [31:0] nx_q, ny_q, nz_q, s1_q, s2_q, t_q, mean_q;
  logic [FRAC_BITS:0] w_q, sq1_q, sq2_q, w_in;
  logic               pass_q;
  logic [SA_W-1:0]    sidx_q;
  logic signed [31:0] u_q, g_q, c_q, s_q;
  logic [30:0]        len_q;
  logic [MC_W-1:0]    m_q, nmodes_q, nmodes_in;
  logic [63:0]        mag2_q, lim_q;
  logic signed [63:0] dot_q, v_q;
  logic signed [63:0] acc_q [3];
  logic               num_neg_q, sel_q;
  logic [31:0]        ang_q;
  logic [30:0]        sx_q, x2_q;
  logic [1:0]         quad_q, comp_q;
  logic               out_valid_q;
  fmts_out_t          out_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept && in_req_i.cmd == CMD_LOAD_MODE && int'(in_req_i.slot) < N_MODES) begin
      mode_mem[in_req_i.slot[MA_W-1:0]] <= {in_req_i.vec_c_z, in_req_i.vec_c_y,
        in_req_i.vec_c_x, in_req_i.vec_b_z, in_req_i.vec_b_y, in_req_i.vec_b_x,
        in_req_i.vec_a_z, in_req_i.vec_a_y, in_req_i.vec_a_x};
    end
    if (accept && in_req_i.cmd == CMD_LOAD_SEED && int'(in_req_i.slot) < N_SEEDS) begin
      seed_mem[in_req_i.slot[SA_W-1:0]] <= {in_req_i.vec_a_z, in_req_i.vec_a_y,
                                            in_req_i.vec_a_x};
    end
    mode_rd_q <= mode_mem[m_q[MA_W-1:0]];
    seed_rd_q <= seed_mem[sidx_q];
  end

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q, prod_fl;
  logic signed [63:0] prod_sh;
  logic [31:0]        prod_q30;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  assign prod_fl  = prod_q >>> FRAC_BITS;
  assign prod_sh  = prod_fl[63:0];
  assign prod_q30 = prod_q[61:30];

  logic [31:0] pw, qw;
  logic signed [31:0] sq_sel;
  assign pw = mode_rd_q[4'd3 + {2'b00, comp_q}];
  assign qw = mode_rd_q[4'd6 + {2'b00, comp_q}];
  assign sq_sel = pass_q ? 32'(sq2_q) : 32'(sq1_q);

  // sqrt and divider
  logic        sqrt_start, sqrt_done;
  logic [63:0] sqrt_rad;
  logic [31:0] root;
  logic        div_start, div_long, div_done;
  logic [63:0] div_dvd;
  logic [30:0] div_rem_in, div_rem;
  logic [31:0] div_quo;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SEED:  begin mul_a = sx33(seed_rd_q[1]); mul_b = zx33(sq_sel); end
      ST_K0:    begin mul_a = sx33(mode_rd_q[0]); mul_b = sx33(mode_rd_q[0]); end
      ST_K1:    begin mul_a = sx33(mode_rd_q[1]); mul_b = sx33(mode_rd_q[1]); end
      ST_K2:    begin mul_a = sx33(mode_rd_q[2]); mul_b = sx33(mode_rd_q[2]); end
      ST_K3:    begin mul_a = sx33(mode_rd_q[0]); mul_b = sx33(nx_q); end
      ST_K4:    begin mul_a = sx33(mode_rd_q[1]); mul_b = sx33(ny_q); end
      ST_K5:    begin mul_a = sx33(mode_rd_q[2]); mul_b = sx33(nz_q); end
      ST_K6:    begin mul_a = zx33({1'b0, cutoff_q}); mul_b = zx33({1'b0, len_q}); end
      ST_SQK:   begin mul_a = zx33(root); mul_b = zx33({1'b0, mesh_q}); end
      ST_CUT:   begin mul_a = sx33(mode_rd_q[0]); mul_b = sx33(u_q); end
      ST_DRIFT: begin mul_a = sx33(sat32(prod_sh)); mul_b = sx33(t_q); end
      ST_T0:    begin mul_a = zx33({1'b0, sx_q}); mul_b = zx33({1'b0, sx_q}); end
      ST_T1:    begin mul_a = zx33({1'b0, prod_q30[30:0]}); mul_b = zx33(SIN_A9); end
      ST_T2:    begin mul_a = zx33({1'b0, x2_q}); mul_b = zx33(SIN_A7 - prod_q30); end
      ST_T3:    begin mul_a = zx33({1'b0, x2_q}); mul_b = zx33(SIN_A5 - prod_q30); end
      ST_T4:    begin mul_a = zx33({1'b0, x2_q}); mul_b = zx33(SIN_A3 - prod_q30); end
      ST_T5:    begin mul_a = zx33({1'b0, sx_q}); mul_b = zx33(SIN_A1 - prod_q30); end
      ST_C0:    begin mul_a = sx33(pw); mul_b = sx33(c_q); end
      ST_C1:    begin mul_a = sx33(qw); mul_b = sx33(s_q); end
      ST_C2:    begin mul_a = sx33(sat32(v_q + prod_sh)); mul_b = sx33(g_q); end
      default: ;
    endcase
  end

  // compute request decode
  logic signed [31:0] wb;
  always_comb begin
    wb = in_req_i.vec_b_z;
    if (wb[31])                        w_in = '0;
    else if ({32'd0, wb} > QONE)       w_in = QONE[FRAC_BITS:0];
    else                               w_in = wb[FRAC_BITS:0];
    if (int'(active_q) < N_MODES)      nmodes_in = MC_W'(active_q);
    else                               nmodes_in = MC_W'(N_MODES);
  end

  assign sqrt_start = (accept && in_req_i.cmd == CMD_COMPUTE) ||
                      (state_q == ST_SQ1 && sqrt_done) || (state_q == ST_K4);
  always_comb begin
    case (state_q)
      ST_IDLE: sqrt_rad = 64'(w_in) << FRAC_BITS;
      ST_SQ1:  sqrt_rad = (QONE - 64'(w_q)) << FRAC_BITS;
      default: sqrt_rad = mag2_q;
    endcase
  end

  // phase numerator and modulo fix-up
  logic [15:0]        off_i;
  logic signed [63:0] num;
  logic [63:0]        num_mag;
  logic [30:0]        r_fix;
  logic signed [31:0] sidx_raw, len_c;
  logic               sidx_ok;
  logic [31:0]        ang_t, rr, sv;

  always_comb begin
    off_i    = 16'(sidx_q) * 16'd100 + 16'(m_q) * 16'd10;
    num      = dot_q - prod_sh + $signed(64'(off_i) << FRAC_BITS);
    num_mag  = num[63] ? 64'(-num) : 64'(num);
    r_fix    = (num_neg_q && div_rem != '0) ? (len_q - div_rem) : div_rem;
    sidx_raw = pass_q ? s2_q : s1_q;
    sidx_ok  = !sidx_raw[31] && (int'(sidx_raw) < N_SEEDS);
    len_c    = ($signed(seed_rd_q[2]) < $signed({1'b0, minlen_q})) ?
               $signed({1'b0, minlen_q}) : $signed(seed_rd_q[2]);
    ang_t    = sel_q ? ang_q : (ang_q + 32'h4000_0000);
    rr       = (prod_q30 > 32'h4000_0000) ? 32'h4000_0000 : prod_q30;
    sv       = rr >> (30 - FRAC_BITS);
  end

  assign div_start  = (state_q == ST_NUM) || (state_q == ST_DIV1 && div_done);
  assign div_long   = (state_q == ST_NUM);
  assign div_dvd    = (state_q == ST_NUM) ? num_mag : '0;
  assign div_rem_in = (state_q == ST_NUM) ? '0 : r_fix;

  fmts_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  fmts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .long_i  (div_long),
    .dvd_i   (div_dvd),
    .rem_i   (div_rem_in),
    .den_i   (len_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // final clamp
  logic signed [32:0] lo;
  logic signed [63:0] ax;
  always_comb begin
    lo = {minvel_q[31], minvel_q} - {mean_q[31], mean_q};
    ax = (acc_q[0] < 64'(lo)) ? 64'(lo) : acc_q[0];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pass_q      <= 1'b0;
      m_q         <= '0;
      comp_q      <= '0;
      sel_q       <= 1'b0;
      sidx_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_FIN) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (accept && in_req_i.cmd == CMD_COMPUTE) state_q <= ST_SQ1;
        ST_SQ1:  if (sqrt_done) state_q <= ST_SQ2;
        ST_SQ2:  if (sqrt_done) begin
          pass_q  <= 1'b0;
          state_q <= ST_PASS;
        end
        ST_PASS: if (sidx_ok) begin
          sidx_q  <= sidx_raw[SA_W-1:0];
          state_q <= ST_SRD;
        end else begin
          state_q <= ST_PEND;
        end
        ST_SRD:  state_q <= ST_SEED;
        ST_SEED: begin
          m_q <= '0;
          if (len_c[31] || len_c == 32'sd0 || nmodes_q == '0) state_q <= ST_PEND;
          else                                                 state_q <= ST_GAIN;
        end
        ST_GAIN: state_q <= ST_MRD;
        ST_MRD:  state_q <= ST_K0;
        ST_K0:   state_q <= ST_K1;
        ST_K1:   state_q <= ST_K2;
        ST_K2:   state_q <= ST_K3;
        ST_K3:   state_q <= ST_K4;
        ST_K4:   state_q <= ST_K5;
        ST_K5:   state_q <= ST_K6;
        ST_K6:   state_q <= ST_CUTL;
        ST_CUTL: state_q <= ST_SQK;
        ST_SQK:  if (sqrt_done) state_q <= ST_CUT;
        ST_CUT:  state_q <= (prod_q[63:0] > lim_q) ? ST_NEXT : ST_DRIFT;
        ST_DRIFT: state_q <= ST_NUM;
        ST_NUM:  state_q <= ST_DIV1;
        ST_DIV1: if (div_done) state_q <= ST_DIV2;
        ST_DIV2: if (div_done) begin
          sel_q   <= 1'b0;
          state_q <= ST_TSET;
        end
        ST_TSET: state_q <= ST_T0;
        ST_T0:   state_q <= ST_T1;
        ST_T1:   state_q <= ST_T2;
        ST_T2:   state_q <= ST_T3;
        ST_T3:   state_q <= ST_T4;
        ST_T4:   state_q <= ST_T5;
        ST_T5:   state_q <= ST_T6;
        ST_T6:   if (!sel_q) begin
          sel_q   <= 1'b1;
          state_q <= ST_TSET;
        end else begin
          comp_q  <= '0;
          state_q <= ST_C0;
        end
        ST_C0:   state_q <= ST_C1;
        ST_C1:   state_q <= ST_C2;
        ST_C2:   state_q <= ST_C3;
        ST_C3:   if (comp_q == 2'd2) begin
          state_q <= ST_NEXT;
        end else begin
          comp_q  <= comp_q + 2'd1;
          state_q <= ST_C0;
        end
        ST_NEXT: if ({1'b0, m_q} + 1'b1 < {1'b0, nmodes_q}) begin
          m_q     <= m_q + 1'b1;
          state_q <= ST_MRD;
        end else begin
          state_q <= ST_PEND;
        end
        ST_PEND: if (!pass_q) begin
          pass_q  <= 1'b1;
          state_q <= ST_PASS;
        end else begin
          state_q <= ST_FIN;
        end
        ST_FIN:  if (!out_valid_q || out_ready_i) begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (accept && in_req_i.cmd == CMD_COMPUTE) begin
        tag_q    <= in_req_i.slot;
        nx_q     <= in_req_i.vec_a_x;
        ny_q     <= in_req_i.vec_a_y;
        nz_q     <= in_req_i.vec_a_z;
        s1_q     <= in_req_i.vec_b_x;
        s2_q     <= in_req_i.vec_b_y;
        w_q      <= w_in;
        t_q      <= in_req_i.vec_c_x;
        mean_q   <= in_req_i.vec_c_y;
        nmodes_q <= nmodes_in;
        acc_q[0] <= '0;
        acc_q[1] <= '0;
        acc_q[2] <= '0;
      end
      ST_SQ1:  if (sqrt_done) sq1_q <= root[FRAC_BITS:0];
      ST_SQ2:  if (sqrt_done) sq2_q <= root[FRAC_BITS:0];
      ST_SEED: begin
        u_q   <= seed_rd_q[0];
        len_q <= len_c[30:0];
      end
      ST_GAIN: g_q <= prod_sh[31:0];
      ST_K1:   mag2_q <= prod_q[63:0];
      ST_K2:   mag2_q <= mag2_q + prod_q[63:0];
      ST_K3:   mag2_q <= mag2_q + prod_q[63:0];
      ST_K4:   dot_q <= prod_sh;
      ST_K5:   dot_q <= dot_q + prod_sh;
      ST_K6:   dot_q <= dot_q + prod_sh;
      ST_CUTL: lim_q <= prod_q[63:0];
      ST_NUM:  num_neg_q <= num[63];
      ST_DIV2: if (div_done) ang_q <= div_quo;
      ST_TSET: begin
        quad_q <= ang_t[31:30];
        sx_q   <= ang_t[30] ? (31'h4000_0000 - {1'b0, ang_t[29:0]}) : {1'b0, ang_t[29:0]};
      end
      ST_T1:   x2_q <= prod_q30[30:0];
      ST_T6:   if (!sel_q) c_q <= quad_q[1] ? -$signed(sv) : $signed(sv);
               else        s_q <= quad_q[1] ? -$signed(sv) : $signed(sv);
      ST_C1:   v_q <= prod_sh;
      ST_C3:   acc_q[comp_q] <= sat_add(acc_q[comp_q], prod_sh);
      ST_FIN:  if (!out_valid_q || out_ready_i) begin
        out_q.node_tag     <= tag_q;
        out_q.flu_axial    <= sat32(ax);
        out_q.flu_lateral  <= sat32(acc_q[1]);
        out_q.flu_vertical <= sat32(acc_q[2]);
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_fin_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!out_valid_q || out_ready_i)) |=>
      (out_valid_q && state_q == ST_IDLE))
    else $error("finished node not presented");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("response raised outside finish");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_K0) |-> (m_q < nmodes_q))
    else $error("mode index beyond active count");

  a_len_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GAIN) |-> (len_q != '0))
    else $error("seed pass with zero length scale");

endmodule
